FILE: sv/srde_pkg.sv
`timescale 1ns / 1ps

package srde_pkg;

  localparam int unsigned IndexWidth = 10;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RowWidth   = 16;
  localparam int unsigned AccWidth   = 64;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CmdWidth   = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_WRITE = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } stage_t;

endpackage

FILE: sv/srde_vec_mem.sv
`timescale 1ns / 1ps

module srde_vec_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [AW-1:0]                          waddr,
  input  logic [srde_pkg::ValueWidth-1:0]        wdata,
  input  logic                                   re,
  input  logic [AW-1:0]                          raddr,
  output logic [srde_pkg::ValueWidth-1:0]        rdata
);

  logic [srde_pkg::ValueWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/srde_acc.sv
`timescale 1ns / 1ps

module srde_acc (
  input  logic                                     clk,
  input  logic                                     rst,
  input  srde_pkg::stage_t                         in_stage,
  input  logic signed [srde_pkg::ValueWidth-1:0]   op_a,
  input  logic signed [srde_pkg::ValueWidth-1:0]   op_b,
  output logic                                     adv,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [srde_pkg::RowWidth-1:0]            row_number,
  output logic [srde_pkg::ValueWidth-1:0]          row_sum,
  output logic                                     saturated
);

  localparam int unsigned TermWidth = 2 * srde_pkg::ValueWidth - srde_pkg::FracBits;

  srde_pkg::stage_t                          st;
  logic signed [srde_pkg::AccWidth-1:0]      prod;
  logic signed [srde_pkg::AccWidth-1:0]      acc;
  logic signed [srde_pkg::AccWidth-1:0]      acc_next;
  logic [srde_pkg::RowWidth-1:0]             row;
  logic signed [TermWidth-1:0]               term;
  logic [srde_pkg::AccWidth:0]               sum;
  logic                                      clip;
  logic [srde_pkg::ValueWidth-1:0]           clipped;

  assign adv  = !out_valid || out_ready;
  assign term = prod[srde_pkg::AccWidth-1:srde_pkg::FracBits];
  assign sum  = {acc[srde_pkg::AccWidth-1], acc}
              + {{(srde_pkg::AccWidth+1-TermWidth){term[TermWidth-1]}}, term};

  always_comb begin
    if (sum[srde_pkg::AccWidth] != sum[srde_pkg::AccWidth-1]) begin
      acc_next = sum[srde_pkg::AccWidth]
               ? {1'b1, {(srde_pkg::AccWidth-1){1'b0}}}
               : {1'b0, {(srde_pkg::AccWidth-1){1'b1}}};
    end else begin
      acc_next = sum[srde_pkg::AccWidth-1:0];
    end
  end

  always_comb begin
    clip = !((&acc[srde_pkg::AccWidth-1:srde_pkg::ValueWidth-1]) ||
             !(|acc[srde_pkg::AccWidth-1:srde_pkg::ValueWidth-1]));
    if (clip) begin
      clipped = acc[srde_pkg::AccWidth-1]
              ? {1'b1, {(srde_pkg::ValueWidth-1){1'b0}}}
              : {1'b0, {(srde_pkg::ValueWidth-1){1'b1}}};
    end else begin
      clipped = acc[srde_pkg::ValueWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      acc       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      st        <= in_stage;
      out_valid <= 1'b0;
      if (st.valid) begin
        case (st.cmd)
          srde_pkg::CMD_WRITE: begin
            acc <= '0;
            row <= '0;
          end
          srde_pkg::CMD_ACC: begin
            acc <= acc_next;
          end
          srde_pkg::CMD_END: begin
            row_number <= row;
            row_sum    <= clipped;
            saturated  <= clip;
            out_valid  <= 1'b1;
            acc        <= '0;
            row        <= row + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    adv && st.valid && st.cmd == srde_pkg::CMD_WRITE |=> acc == '0 && row == '0)
    else $error("write did not clear accumulator and row");

  a_end_advances: assert property (@(posedge clk) disable iff (rst)
    adv && st.valid && st.cmd == srde_pkg::CMD_END
      |=> out_valid && acc == '0 && row == $past(row) + 1'b1 && row_number == $past(row))
    else $error("row end did not emit and advance");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (row_sum == 32'h7FFF_FFFF || row_sum == 32'h8000_0000))
    else $error("saturated result not at a bound");

endmodule

FILE: sv/sparse_row_dot_engine_unit.sv
`timescale 1ns / 1ps

// Sparse matrix times dense vector, one compressed row at a time, in signed
// Q16.16. Load the vector with write transactions (tuser 0), stream a row's
// nonzero entries (tuser 1), then close the row (tuser 2) to get one result
// transaction with the row number and the sum clipped to 32 bits. A vector
// write also clears the running sum and the row number. The block takes one
// transaction per cycle; an item goes through the vector store read, the
// multiplier register and then the accumulator into the result register, and
// input stalls only during reset and while a result sits unclaimed in the
// output register.
// Vector entries that were never written read back undefined.

module sparse_row_dot_engine_unit #(
  parameter int unsigned VECTOR_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // index[9:0], value[41:10], zero pad
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row_number[15:0], row_sum[47:16]
  output logic        m_axis_tuser    // saturated
);

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic                                      adv;
  logic                                      accept;
  srde_pkg::cmd_t                            cmd;
  logic [srde_pkg::IndexWidth-1:0]           index;
  logic [srde_pkg::ValueWidth-1:0]           value;
  logic                                      in_range;
  logic [AW-1:0]                             addr;
  logic [srde_pkg::ValueWidth-1:0]           rdata;
  srde_pkg::stage_t                          s1;
  logic signed [srde_pkg::ValueWidth-1:0]    s1_value;
  logic                                      s1_in_range;
  logic signed [srde_pkg::ValueWidth-1:0]    element;
  logic [srde_pkg::RowWidth-1:0]             row_number;
  logic [srde_pkg::ValueWidth-1:0]           row_sum;

  assign s_axis_tready = adv && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = srde_pkg::cmd_t'(s_axis_tuser);
  assign index         = s_axis_tdata[srde_pkg::IndexWidth-1:0];
  assign value         = s_axis_tdata[srde_pkg::IndexWidth +: srde_pkg::ValueWidth];
  assign in_range      = 32'(index) < VECTOR_DEPTH;
  assign addr          = AW'(index);
  assign element       = s1_in_range ? rdata : '0;

  srde_vec_mem #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (accept && cmd == srde_pkg::CMD_WRITE && in_range),
    .waddr (addr),
    .wdata (value),
    .re    (accept),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (adv) begin
      s1.valid <= accept;
      s1.cmd   <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value    <= value;
      s1_in_range <= in_range;
    end
  end

  srde_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .in_stage   (s1),
    .op_a       (s1_value),
    .op_b       (element),
    .adv        (adv),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .row_number (row_number),
    .row_sum    (row_sum),
    .saturated  (m_axis_tuser)
  );

  assign m_axis_tdata = {row_sum, row_number};

endmodule

FILE: bench/sparse_row_dot_engine_unit_tb.sv
`timescale 1ns / 1ps

module sparse_row_dot_engine_unit_tb;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [31:0] Q_ONE      = 32'h0001_0000;
  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;
  localparam logic [31:0] Q_LSB_NEG  = 32'hFFFF_FFFF;
  localparam int unsigned OVERFLOW_RUN  = 6;
  localparam int unsigned EMPTY_ROW_RUN = 6;

  typedef struct {
    logic [15:0] row;
    logic [31:0] sum;
    logic        sat;
  } row_sum_t;

  class row_sum_scoreboard;
    logic [31:0] vector_mem [1024];
    longint      running_sum;
    logic [15:0] row_count;
    row_sum_t    pending_sums [$];
    int          errors;

    function new();
      running_sum = 0;
      row_count   = '0;
      errors      = 0;
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    function bit note_error();
      errors++;
      return errors <= 100;
    endfunction

    function void take_item(logic [1:0] cmd, logic [9:0] idx, logic [31:0] val);
      longint        term;
      logic [64:0]   wide;
      longint        clipped;
      row_sum_t      res;
      if (cmd == srde_pkg::CMD_WRITE) begin
        vector_mem[idx] = val;
        running_sum     = 0;
        row_count       = '0;
      end else if (cmd == srde_pkg::CMD_ACC) begin
        term = (longint'(signed'(val)) * longint'(signed'(vector_mem[idx])))
               >>> srde_pkg::FracBits;
        wide = {running_sum[63], running_sum} + {term[63], term};
        if (wide[64] != wide[63])
          running_sum = wide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
          running_sum = wide[63:0];
      end else if (cmd == srde_pkg::CMD_END) begin
        res.sat = 1'b1;
        if (running_sum > 64'sh7FFF_FFFF)
          clipped = 64'sh7FFF_FFFF;
        else if (running_sum < -64'sh8000_0000)
          clipped = -64'sh8000_0000;
        else begin
          clipped = running_sum;
          res.sat = 1'b0;
        end
        res.row = row_count;
        res.sum = clipped[31:0];
        pending_sums.push_back(res);
        running_sum = 0;
        row_count   = row_count + 16'd1;
      end
    endfunction

    function void match_row_sum(logic [15:0] row, logic [31:0] sum, logic sat);
      row_sum_t want;
      if (pending_sums.size() == 0) begin
        if (note_error())
          $display("%0t: unexpected result row %0d sum %h sat %b", $time, row, sum, sat);
        return;
      end
      want = pending_sums.pop_front();
      if (row !== want.row && note_error())
        $display("%0t: row_number expected %0d actual %0d", $time, want.row, row);
      if (sum !== want.sum && note_error())
        $display("%0t: row_sum expected %h actual %h (row %0d)", $time, want.sum, sum, want.row);
      if (sat !== want.sat && note_error())
        $display("%0t: saturated expected %b actual %b (row %0d)", $time, want.sat, sat, want.row);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  row_sum_scoreboard sb = new();
  int unsigned       loaded_idx [$];
  bit                loaded [1024];

  sparse_row_dot_engine_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.match_row_sum(m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tuser);
  end

  task automatic send_item(input logic [1:0] cmd, input logic [9:0] idx,
                           input logic [31:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, idx};
    s_axis_tuser  <= cmd;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    sb.take_item(cmd, idx, val);
  endtask

  task automatic load_element(input logic [9:0] idx, input logic [31:0] val);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
    end
    send_item(srde_pkg::CMD_WRITE, idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom;
    if (pick < 70) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    if (pick < 85) begin
      case ($urandom_range(4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return '0;
        3: return Q_LSB_NEG;
        default: return Q_ONE;
      endcase
    end
    return {{8{1'($urandom_range(1))}}, 24'($urandom)};
  endfunction

  function automatic logic [9:0] random_column();
    return 10'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
  endfunction

  task automatic random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        load_element(10'($urandom_range(1023)), random_value());
        sent++;
      end else if (roll < 11) begin
        send_item(CMD_UNUSED, 10'($urandom_range(1023)), $urandom);
      end else begin
        len = $urandom_range(8);
        repeat (len) begin
          send_item(srde_pkg::CMD_ACC, random_column(), random_value());
          sent++;
        end
        if (roll < 91) begin
          send_item(srde_pkg::CMD_END, 10'($urandom_range(1023)), $urandom);
          sent++;
        end
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("sparse_row_dot_engine_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    load_element(10'd0, Q_MAX);
    load_element(10'd1023, Q_MIN);
    load_element(10'd1, Q_ONE);
    load_element(10'd2, Q_LSB_NEG);
    load_element(10'd512, '0);
    send_item(srde_pkg::CMD_ACC, 10'd1, 32'h0001_8000);
    send_item(srde_pkg::CMD_ACC, 10'd2, 32'h0000_0001);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(srde_pkg::CMD_END, 10'd1023, Q_LSB_NEG);
    send_item(srde_pkg::CMD_ACC, 10'd0, Q_MAX);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(srde_pkg::CMD_ACC, 10'd1023, Q_MAX);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(srde_pkg::CMD_ACC, 10'd1023, Q_MIN);
    send_item(srde_pkg::CMD_ACC, 10'd512, 32'h1234_5678);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(CMD_UNUSED, 10'd1023, Q_LSB_NEG);
    send_item(srde_pkg::CMD_ACC, 10'd1, Q_MIN);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(srde_pkg::CMD_ACC, 10'd1, Q_MAX);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    send_item(srde_pkg::CMD_ACC, 10'd1, Q_ONE);
    load_element(10'd3, 32'd5);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    drain();

    repeat (OVERFLOW_RUN) send_item(srde_pkg::CMD_ACC, 10'd1023, Q_MIN);
    send_item(srde_pkg::CMD_ACC, 10'd0, Q_LSB_NEG);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    repeat (OVERFLOW_RUN) send_item(srde_pkg::CMD_ACC, 10'd1023, Q_MAX);
    send_item(srde_pkg::CMD_ACC, 10'd1, Q_ONE);
    send_item(srde_pkg::CMD_END, 10'd0, '0);
    repeat (EMPTY_ROW_RUN) send_item(srde_pkg::CMD_END, 10'($urandom_range(1023)), $urandom);
    drain();

    random_traffic(250);
    src_idle_pct = 81;
    random_traffic(250);
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 81;
    random_traffic(250);
    src_idle_pct   = 28;
    sink_stall_pct = 28;
    random_traffic(250);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_traffic(50);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("sparse_row_dot_engine_unit regression: pass");
    else
      $display("sparse_row_dot_engine_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
sv/srde_pkg.sv
sv/srde_vec_mem.sv
sv/srde_acc.sv
sv/sparse_row_dot_engine_unit.sv
bench/sparse_row_dot_engine_unit_tb.sv
